>>> design/rksc_pkg.sv
// ----------------------------------------------------------------------------
// rksc_pkg
// Shared types and constants for the rotating key substitution cipher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rksc_pkg;

  localparam int KEY_MAX = 128;
  localparam int KEY_AW  = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int LEN_W   = $clog2(KEY_MAX + 1);
  localparam int CMP_W   = (LEN_W > 8) ? LEN_W : 8;

  localparam int ALPHA    = 26;
  localparam int LETTER_W = 5;

  typedef enum logic [1:0] {
    OP_KEY   = 2'd0,
    OP_TABLE = 2'd1,
    OP_ENC   = 2'd2
  } op_t;

  typedef struct packed {
    logic adv;
    logic start;
  } step_t;

  function automatic logic [LETTER_W-1:0] mod26(input logic [LETTER_W-1:0] v);
    mod26 = (v >= LETTER_W'(ALPHA)) ? v - LETTER_W'(ALPHA) : v;
  endfunction

endpackage

>>> design/rotating_key_substitution_cipher_top.sv
// ----------------------------------------------------------------------------
// rotating_key_substitution_cipher_top
// Rotating-key substitution cipher, one letter per word.
//
//   channel  dir  handshake            payload
//   in       in   in_tvalid/in_tready  tdata: entry_index, letter; tuser: opcode,
//                                      is_upper, message_start
//   out      out  out_tvalid/out_tready tdata: cipher_letter; tuser: cipher_upper
//   cfg      in   cfg_valid/cfg_ready  cfg_data: key_length
//
// One word per cycle sustained while out_tready stays high; an accepted word passes through
// the registered key RAM read stage and then the output register.
// Write words give no result. Reset clears position, rotation and key_length (1);
// key and table contents are undefined until written.
// Input stalls only when both the RAM stage and the output register are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotating_key_substitution_cipher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [6:0] entry_index, [11:7] letter, zero pad
  input  logic [3:0]  in_tuser,   // [1:0] opcode, [2] is_upper, [3] message_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [4:0] cipher_letter, zero pad
  output logic [0:0]  out_tuser,  // [0] cipher_upper
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  import rksc_pkg::*;

  logic [7:0]          key_length_r;
  logic                in_acc, s1_adv;
  op_t                 op;
  logic [6:0]          idx;
  logic [LETTER_W-1:0] letter;
  logic                key_we, tbl_we, enc;
  step_t               step;
  logic [KEY_AW-1:0]   kpos;
  logic [LETTER_W-1:0] key_rd, cipher;

  logic                s1_valid_r, s1_valid_nxt;
  logic [LETTER_W-1:0] s1_letter_r;
  logic                s1_upper_r;
  logic                out_valid_r, out_valid_nxt;
  logic [LETTER_W-1:0] out_letter_r;
  logic                out_upper_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      key_length_r <= cfg_data;
    end
  end

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;
  assign op        = op_t'(in_tuser[1:0]);
  assign idx       = in_tdata[6:0];
  assign letter    = in_tdata[11:7];

  always_comb begin
    key_we = 1'b0;
    tbl_we = 1'b0;
    enc    = 1'b0;
    case (op)
      OP_KEY:   key_we = in_acc && (CMP_W'(idx) < CMP_W'(KEY_MAX));
      OP_TABLE: tbl_we = in_acc;
      OP_ENC:   enc    = in_acc;
      default:  ;
    endcase
  end

  assign step.adv   = enc;
  assign step.start = in_tuser[3];

  rksc_keypos u_keypos (
    .clk        (clk),
    .rst_n      (rst_n),
    .key_length (key_length_r),
    .step       (step),
    .kpos       (kpos)
  );

  rksc_ram #(
    .WIDTH (LETTER_W),
    .DEPTH (KEY_MAX)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (KEY_AW'(idx)),
    .wdata (letter),
    .re    (enc),
    .raddr (kpos),
    .rdata (key_rd)
  );

  rksc_subst u_subst (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_idx  (idx),
    .wr_data (letter),
    .plain   (s1_letter_r),
    .key_raw (key_rd),
    .cipher  (cipher)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = enc;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enc) begin
      s1_letter_r <= letter;
      s1_upper_r  <= in_tuser[2];
    end
    if (s1_adv && s1_valid_r) begin
      out_letter_r <= cipher;
      out_upper_r  <= s1_upper_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {3'b000, out_letter_r};
  assign out_tuser[0] = out_upper_r;

  a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[4:0] < 5'd26))
    else $error("cipher letter out of range");

  a_enc_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (op == OP_ENC)) |=> s1_valid_r)
    else $error("enciphered word lost after acceptance");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled with room in pipeline");

  a_hold_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_letter_r)))
    else $error("stalled stage lost its word");

endmodule

>>> design/rksc_ram.sv
// ----------------------------------------------------------------------------
// rksc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rksc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/rksc_keypos.sv
// ----------------------------------------------------------------------------
// rksc_keypos
// Block position and rotation tracking; gives the key address per letter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rksc_keypos (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [7:0]                 key_length,
  input  rksc_pkg::step_t            step,
  output logic [rksc_pkg::KEY_AW-1:0] kpos
);

  import rksc_pkg::*;

  logic [KEY_AW-1:0] pos_r, pos_nxt;
  logic [KEY_AW-1:0] rot_r, rot_nxt;
  logic [CMP_W-1:0]  kl_w;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  p0, r0, p1, r1;
  logic [LEN_W:0]    wrap;

  always_comb begin
    kl_w = CMP_W'(key_length);
    if (kl_w == '0) begin
      len = LEN_W'(1);
    end else if (kl_w > CMP_W'(KEY_MAX)) begin
      len = LEN_W'(KEY_MAX);
    end else begin
      len = LEN_W'(kl_w);
    end

    p0 = step.start ? '0 : LEN_W'(pos_r);
    r0 = step.start ? '0 : LEN_W'(rot_r);
    if (p0 >= len) p0 = '0;
    if (r0 >= len) r0 = '0;

    wrap = {1'b0, p0} + {1'b0, len} - {1'b0, r0};
    kpos = (p0 >= r0) ? KEY_AW'(p0 - r0) : KEY_AW'(wrap);

    p1 = p0 + LEN_W'(1);
    r1 = r0 + LEN_W'(1);
    pos_nxt = pos_r;
    rot_nxt = rot_r;
    if (step.adv) begin
      if (p1 >= len) begin
        pos_nxt = '0;
        rot_nxt = (r1 >= len) ? '0 : KEY_AW'(r1);
      end else begin
        pos_nxt = KEY_AW'(p1);
        rot_nxt = KEY_AW'(r0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      rot_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      rot_r <= rot_nxt;
    end
  end

endmodule

>>> design/rksc_subst.sv
// ----------------------------------------------------------------------------
// rksc_subst
// Substitution table and the mod-26 add, look-up and subtract datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rksc_subst (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [6:0]                    wr_idx,
  input  logic [rksc_pkg::LETTER_W-1:0] wr_data,
  input  logic [rksc_pkg::LETTER_W-1:0] plain,
  input  logic [rksc_pkg::LETTER_W-1:0] key_raw,
  output logic [rksc_pkg::LETTER_W-1:0] cipher
);

  import rksc_pkg::*;

  logic [LETTER_W-1:0] tbl [ALPHA];
  logic [LETTER_W-1:0] k, s, t;
  logic [LETTER_W:0]   sum_w;
  logic [LETTER_W-1:0] sum;

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx < 7'(ALPHA))) begin
      tbl[wr_idx[LETTER_W-1:0]] <= wr_data;
    end
  end

  always_comb begin
    k     = mod26(key_raw);
    s     = mod26(plain);
    sum_w = {1'b0, s} + {1'b0, k};
    sum   = (sum_w >= (LETTER_W+1)'(ALPHA)) ? LETTER_W'(sum_w - (LETTER_W+1)'(ALPHA))
                                           : LETTER_W'(sum_w);
    t      = mod26(tbl[sum]);
    cipher = (t >= k) ? t - k : t + LETTER_W'(ALPHA) - k;
  end

endmodule

>>> sim/rotating_key_substitution_cipher_top_test.sv
// ----------------------------------------------------------------------------
// rotating_key_substitution_cipher_top_test
// Self-checking bench for the rotating key substitution cipher. Loads the
// table and key, runs directed corner words, then random messages under a
// range of key lengths while both stream sides idle and stall at random.
// Every result is checked against a behavioural cipher model in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotating_key_substitution_cipher_top_test;
  import rksc_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         IDLE_LIMIT  = 2000;
  localparam int         TARGET_WORDS = 750;

  typedef struct {
    logic [1:0]          op;
    logic [6:0]          index;
    logic [LETTER_W-1:0] letter;
    logic                upper;
    logic                start;
  } cipher_word_t;

  typedef struct {
    logic [LETTER_W-1:0] letter;
    logic                upper;
  } cipher_result_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic [3:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data   = '0;

  // cipher model state
  logic [LETTER_W-1:0] model_key [KEY_MAX];
  logic [LETTER_W-1:0] model_table [ALPHA];
  int                  model_pos     = 0;
  int                  model_rot     = 0;
  logic [7:0]          model_key_len = 8'd1;

  cipher_word_t   pending_words [$];
  cipher_result_t expected_cipher [$];
  cipher_word_t   next_word;
  cipher_word_t   seen_word;
  cipher_result_t want;

  logic in_taken    = 1'b0;
  int   burst_left  = 0;
  int   gap_left    = 0;
  int   stall_left  = 0;
  int   mode_left   = 0;
  int   ready_mode  = 0;
  int   rx_tick     = 0;
  bit   hold_off_req  = 1'b0;
  bit   hold_off_done = 1'b0;
  int   idle_cycles = 0;
  int   error_count = 0;
  int   words_counted = 0;

  rotating_key_substitution_cipher_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
  end

  function automatic int active_length(input logic [7:0] v);
    if (v == 0) return 1;
    if (v > KEY_MAX) return KEY_MAX;
    return v;
  endfunction

  function automatic int rand_letter();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(26, 31) : $urandom_range(0, 25);
  endfunction

  task automatic log_mismatch(input string msg);
    if (error_count < 10) $display("%s", msg);
    error_count++;
  endtask

  task automatic cipher_predict(input cipher_word_t w);
    int len, kpos, k, sum, t;
    cipher_result_t r;
    len = active_length(model_key_len);
    case (w.op)
      OP_KEY: model_key[w.index] = w.letter;
      OP_TABLE: if (w.index < ALPHA) model_table[w.index] = w.letter;
      OP_ENC: begin
        if (w.start) begin
          model_pos = 0;
          model_rot = 0;
        end
        if (model_pos >= len) model_pos = 0;
        if (model_rot >= len) model_rot = 0;
        kpos = (model_pos + len - model_rot) % len;
        k = model_key[kpos] % ALPHA;
        sum = (w.letter % ALPHA + k) % ALPHA;
        t = model_table[sum] % ALPHA;
        r.letter = LETTER_W'((t + ALPHA - k) % ALPHA);
        r.upper = w.upper;
        expected_cipher.push_back(r);
        model_pos++;
        if (model_pos >= len) begin
          model_pos = 0;
          model_rot = (model_rot + 1) % len;
        end
      end
      default: ;
    endcase
  endtask

  task automatic queue_word(input logic [1:0] op, input int index, input int letter,
                            input bit upper, input bit start);
    cipher_word_t w;
    w.op = op;
    w.index = 7'(index);
    w.letter = LETTER_W'(letter);
    w.upper = upper;
    w.start = start;
    pending_words.push_back(w);
    words_counted++;
  endtask

  task automatic drain_all();
    while (pending_words.size() != 0 || in_tvalid || expected_cipher.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_key_length(input logic [7:0] v);
    drain_all();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // sender: bursts of words with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      // word still waiting for acceptance
    end else if (gap_left > 0) begin
      in_tvalid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_words.size() > 0) begin
      next_word = pending_words.pop_front();
      in_tdata <= {4'b0, next_word.letter, next_word.index};
      in_tuser <= {next_word.start, next_word.upper, next_word.op};
      in_tvalid <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 24);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // receiver: pattern modes plus occasional long hold-offs
  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (hold_off_req && !hold_off_done) begin
      out_tready <= 1'b0;
      stall_left <= 95;
      hold_off_done <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(8, 64);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= $urandom_range(0, 1);
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= rx_tick[1];
      endcase
      if ($urandom_range(0, 499) == 0) stall_left <= $urandom_range(20, 60);
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        if (expected_cipher.size() == 0) begin
          log_mismatch($sformatf("unexpected result: letter %0d upper %0b",
                                 out_tdata[4:0], out_tuser[0]));
        end else begin
          want = expected_cipher.pop_front();
          if (out_tdata[4:0] !== want.letter || out_tuser[0] !== want.upper)
            log_mismatch($sformatf(
              "cipher mismatch: expected letter %0d upper %0b, got letter %0d upper %0b",
              want.letter, want.upper, out_tdata[4:0], out_tuser[0]));
        end
      end
      if (in_tvalid && in_tready) begin
        seen_word.op = in_tuser[1:0];
        seen_word.upper = in_tuser[2];
        seen_word.start = in_tuser[3];
        seen_word.index = in_tdata[6:0];
        seen_word.letter = in_tdata[11:7];
        cipher_predict(seen_word);
      end
      if (cfg_valid && cfg_ready) model_key_len = cfg_data;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0] corner_lengths [8];
    logic [7:0] klen;
    int         phase_len, phase_end, msg_len, cap, r, i, phase;
    corner_lengths = '{8'd0, 8'd128, 8'd255, 8'd2, 8'd5, 8'd1, 8'd127, 8'd129};
    @(posedge rst_n);

    // load every table and key entry before any read
    for (i = 0; i < ALPHA; i++)
      queue_word(OP_TABLE, i, $urandom_range(0, 31), $urandom_range(0, 1), $urandom_range(0, 1));
    for (i = 0; i < KEY_MAX; i++)
      queue_word(OP_KEY, i, $urandom_range(0, 31), $urandom_range(0, 1), $urandom_range(0, 1));

    // corner words under the reset key length
    queue_word(OP_ENC, 0, 0, 0, 1);
    queue_word(OP_ENC, 127, 25, 1, 0);
    queue_word(OP_ENC, 5, 26, 0, 0);
    queue_word(OP_ENC, 90, 31, 1, 1);
    queue_word(OP_UNUSED, 127, 31, 1, 1);
    queue_word(OP_TABLE, 26, 7, 0, 0);
    queue_word(OP_TABLE, 127, 31, 1, 1);
    queue_word(OP_TABLE, 25, 31, 0, 0);
    queue_word(OP_TABLE, 0, 0, 1, 1);
    queue_word(OP_KEY, 127, 31, 0, 1);
    queue_word(OP_KEY, 0, 26, 1, 1);
    queue_word(OP_ENC, 0, 25, 0, 0);
    queue_word(OP_ENC, 0, 0, 1, 0);
    queue_word(OP_ENC, 0, 31, 0, 0);
    drain_all();

    phase = 0;
    while (words_counted < TARGET_WORDS) begin
      klen = (phase < 8) ? corner_lengths[phase] : 8'($urandom_range(0, 255));
      write_key_length(klen);
      phase_len = active_length(klen);
      // sometimes carry on the old message across the length change
      if ($urandom_range(0, 1) == 1) begin
        msg_len = $urandom_range(1, 6);
        for (i = 0; i < msg_len; i++)
          queue_word(OP_ENC, $urandom_range(0, 127), rand_letter(), $urandom_range(0, 1), 0);
      end
      phase_end = words_counted + 60;
      while (words_counted < phase_end && words_counted < TARGET_WORDS) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          cap = (3 * phase_len + 2 > 300) ? 300 : 3 * phase_len + 2;
          msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, cap) : $urandom_range(1, 12);
          if (msg_len > TARGET_WORDS - words_counted) msg_len = TARGET_WORDS - words_counted;
          for (i = 0; i < msg_len; i++)
            queue_word(OP_ENC, $urandom_range(0, 127), rand_letter(), $urandom_range(0, 1),
                       i == 0);
        end else if (r < 80) begin
          queue_word(OP_KEY, $urandom_range(0, 127), $urandom_range(0, 31),
                     $urandom_range(0, 1), $urandom_range(0, 1));
        end else if (r < 88) begin
          queue_word(OP_TABLE, $urandom_range(0, ALPHA - 1), $urandom_range(0, 31),
                     $urandom_range(0, 1), $urandom_range(0, 1));
        end else if (r < 94) begin
          queue_word(OP_TABLE, $urandom_range(ALPHA, 127), $urandom_range(0, 31),
                     $urandom_range(0, 1), $urandom_range(0, 1));
        end else begin
          queue_word(OP_UNUSED, $urandom_range(0, 127), $urandom_range(0, 31),
                     $urandom_range(0, 1), $urandom_range(0, 1));
        end
      end
      if (phase == 1) hold_off_req = 1'b1;
      drain_all();
      phase++;
    end

    repeat (10) @(posedge clk);
    if (expected_cipher.size() != 0)
      log_mismatch($sformatf("%0d results never arrived", expected_cipher.size()));
    if (error_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

>>> files.f
design/rksc_pkg.sv
design/rksc_ram.sv
design/rksc_keypos.sv
design/rksc_subst.sv
design/rotating_key_substitution_cipher_top.sv
sim/rotating_key_substitution_cipher_top_test.sv
